[src/spme_pkg.sv]
`default_nettype none
package spme_pkg;
    localparam int MaxTermsDef = 256;
    localparam int MaxOrderDef = 8;
    localparam int NCoord = 6;
    localparam int QW = 32;
    localparam int EntryW = 63;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_APPLY = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
        logic signed [31:0] coord_w;
        logic [2:0]         term_target;
        logic [3:0]         term_degree;
        logic [23:0]        term_vars;
        logic signed [31:0] term_coeff;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_u;
        logic signed [31:0] out_v;
        logic signed [31:0] out_w;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] q;
        logic               clip;
    } mul_rsp_t;
endpackage
`default_nettype wire

[src/spme_if.sv]
`default_nettype none
interface spme_in_if;
    import spme_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spme_out_if;
    import spme_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/spme_ram.sv]
`default_nettype none
module spme_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [Width-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [Width-1:0]   rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/spme_qmul.sv]
`default_nettype none
// q16.16 multiply: product registered, then floor shift and clip
module spme_qmul (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire spme_pkg::mul_req_t  req,
    output spme_pkg::mul_rsp_t       rsp
);
    import spme_pkg::*;
    logic signed [63:0] prod_reg;
    logic               vld_reg;
    logic signed [47:0] sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= req.start;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(req.a) * 64'(req.b);
    end

    // arithmetic shift is floor rounding
    assign sh = prod_reg[63:16];

    always_comb
    begin
        rsp.done = vld_reg;
        if (sh > 48'sd2147483647)
        begin
            rsp.q    = 32'sh7fffffff;
            rsp.clip = 1'b1;
        end
        else if (sh < -48'sd2147483648)
        begin
            rsp.q    = 32'sh80000000;
            rsp.clip = 1'b1;
        end
        else
        begin
            rsp.q    = sh[31:0];
            rsp.clip = 1'b0;
        end
    end
endmodule
`default_nettype wire

[src/sparse_polynomial_map_eval_top.sv]
`default_nettype none
// channel   dir  handshake    payload
// in_ch     in   valid/ready  cmd, coords, term fields
// out_ch    out  valid/ready  status, out coords, saturated
// apply steps through the terms in turn with one multiply per factor, as
// set by the one shared multiplier and the term ram read port.
// reset empties the table; ram contents stay undefined until loaded.
// input is not ready while a transaction is in work or its result waits.
module sparse_polynomial_map_eval_top #(
    parameter int MAX_TERMS = spme_pkg::MaxTermsDef,
    parameter int MAX_ORDER = spme_pkg::MaxOrderDef
) (
    input wire logic clk,
    input wire logic rst_n,
    spme_in_if.sink    in_ch,
    spme_out_if.source out_ch
);
    import spme_pkg::*;
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_TERM = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] t_reg;
    logic [3:0]  k_reg;
    logic signed [31:0] x_reg [NCoord];
    logic signed [63:0] acc_reg [NCoord];
    logic signed [31:0] v_reg;
    logic [EntryW-1:0]  e_reg;
    logic        sat_reg;
    out_item_t   res_reg;
    logic        ovalid_reg;

    logic              we;
    logic [AW-1:0]     raddr;
    logic [EntryW-1:0] wdata, rdata;
    mul_req_t mreq;
    mul_rsp_t mrsp;
    logic bad;
    logic [2:0] idx;
    logic [2:0] tgt;
    logic [3:0] deg;
    out_item_t  ack_item;

    function automatic logic signed [31:0] clip(input logic signed [63:0] a);
        if (a > 64'sd2147483647) return 32'sh7fffffff;
        if (a < -64'sd2147483648) return 32'sh80000000;
        return a[31:0];
    endfunction

    spme_ram #(.Width(EntryW), .Depth(MAX_TERMS)) u_ram (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(wdata),
        .raddr(raddr), .rdata(rdata));

    spme_qmul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    assign in_ch.ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = res_reg;

    always_comb
    begin
        bad = (in_ch.data.term_target >= 3'(NCoord)) || (in_ch.data.term_degree == 4'd0)
            || (32'(in_ch.data.term_degree) > MAX_ORDER);
        for (int i = 0; i < 8; i++)
        begin
            if ((i < int'(in_ch.data.term_degree)) && (in_ch.data.term_vars[3*i +: 3] >= 3'(NCoord)))
            begin
                bad = 1'b1;
            end
        end
    end

    // status of the accepted transaction, coordinates cleared
    always_comb
    begin
        ack_item = '0;
        case (in_ch.data.cmd)
            CMD_CLEAR: ack_item.status = ST_OK;
            CMD_LOAD:
            begin
                if (32'(count_reg) >= MAX_TERMS)
                    ack_item.status = ST_FULL;
                else if (bad)
                    ack_item.status = ST_BAD;
                else
                    ack_item.status = ST_OK;
            end
            CMD_APPLY: ack_item.status = ST_DONE;
            default: ack_item.status = ST_BAD;
        endcase
    end

    assign wdata = {in_ch.data.term_coeff, in_ch.data.term_vars, in_ch.data.term_degree,
                    in_ch.data.term_target};
    assign we = in_ch.valid && in_ch.ready && (in_ch.data.cmd == CMD_LOAD) && !bad
                && (32'(count_reg) < MAX_TERMS);
    assign raddr = t_reg[AW-1:0];
    assign tgt = e_reg[2:0];
    assign deg = e_reg[6:3];
    assign idx = (e_reg[7 + 3*k_reg[2:0] +: 3] >= 3'(NCoord)) ? 3'd0 : e_reg[7 + 3*k_reg[2:0] +: 3];

    always_comb
    begin
        mreq.start = (state_reg == S_MUL);
        mreq.a     = v_reg;
        mreq.b     = x_reg[idx];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready && in_ch.data.cmd == CMD_APPLY)
                begin
                    state_next = (count_reg == '0) ? S_FIN : S_RD;
                end
            end
            S_RD:   state_next = S_TERM;
            S_TERM: state_next = S_MUL;
            S_MUL:  state_next = S_WAIT;
            S_WAIT:
            begin
                if (mrsp.done)
                begin
                    state_next = S_MUL;
                    if (k_reg + 4'd1 >= deg)
                    begin
                        state_next = (t_reg + 1'b1 >= count_reg) ? S_FIN : S_RD;
                    end
                end
            end
            S_FIN:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.data.cmd == CMD_CLEAR)
                begin
                    count_reg <= '0;
                end
                if (we)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (in_ch.data.cmd != CMD_APPLY)
                begin
                    ovalid_reg <= 1'b1;
                end
            end
            if (state_reg == S_OUT)
            begin
                ovalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    res_reg <= ack_item;
                    x_reg[0] <= in_ch.data.coord_x;
                    x_reg[1] <= in_ch.data.coord_y;
                    x_reg[2] <= in_ch.data.coord_z;
                    x_reg[3] <= in_ch.data.coord_u;
                    x_reg[4] <= in_ch.data.coord_v;
                    x_reg[5] <= in_ch.data.coord_w;
                    for (int i = 0; i < NCoord; i++)
                    begin
                        acc_reg[i] <= '0;
                    end
                    sat_reg <= 1'b0;
                    t_reg   <= '0;
                end
            end
            S_TERM:
            begin
                e_reg <= rdata;
                v_reg <= rdata[62:31];
                k_reg <= '0;
            end
            S_WAIT:
            begin
                if (mrsp.done)
                begin
                    v_reg   <= mrsp.q;
                    k_reg   <= k_reg + 4'd1;
                    sat_reg <= sat_reg | mrsp.clip;
                    if (k_reg + 4'd1 >= deg)
                    begin
                        acc_reg[tgt] <= acc_reg[tgt] + 64'(mrsp.q);
                        t_reg <= t_reg + 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                for (int i = 0; i < NCoord; i++)
                begin
                    if (acc_reg[i] > 64'sd2147483647 || acc_reg[i] < -64'sd2147483648)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                res_reg.out_x <= clip(acc_reg[0]);
                res_reg.out_y <= clip(acc_reg[1]);
                res_reg.out_z <= clip(acc_reg[2]);
                res_reg.out_u <= clip(acc_reg[3]);
                res_reg.out_v <= clip(acc_reg[4]);
                res_reg.out_w <= clip(acc_reg[5]);
                res_reg.saturated <= sat_reg;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[tb/tb_sparse_polynomial_map_eval_top.sv]
`timescale 1ns / 1ps
module tb_sparse_polynomial_map_eval_top;
    import spme_pkg::*;

    localparam int IdleLimit = 40000;
    localparam int RandItems = 880;

    typedef struct {
        logic [2:0]         tgt;
        logic [3:0]         deg;
        logic [23:0]        vars;
        logic signed [31:0] coeff;
    } term_t;

    logic clk;
    logic rst_n;

    spme_in_if  in_ch ();
    spme_out_if out_ch ();

    sparse_polynomial_map_eval_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor state
    term_t     term_tab[MaxTermsDef];
    int        term_cnt = 0;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    bit        failed = 1'b0;
    bit        stim_done = 1'b0;

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v, output bit c);
        c = 1'b0;
        if (v > 64'sd2147483647)
        begin
            c = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            c = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic out_item_t map_step(input in_item_t it);
        out_item_t          r;
        logic signed [63:0] acc[NCoord];
        logic signed [63:0] xs[NCoord];
        logic signed [63:0] v;
        logic signed [63:0] p;
        logic [2:0]         idx;
        bit                 sat;
        bit                 c;
        bit                 bad;
        r = '0;
        sat = 1'b0;
        case (it.cmd)
            CMD_CLEAR:
            begin
                term_cnt = 0;
                r.status = ST_OK;
            end
            CMD_LOAD:
            begin
                bad = it.term_target >= NCoord || it.term_degree == 0
                      || it.term_degree > MaxOrderDef;
                if (!bad)
                begin
                    for (int k = 0; k < it.term_degree; k++)
                        if (it.term_vars[3*k +: 3] >= NCoord)
                            bad = 1'b1;
                end
                if (term_cnt >= MaxTermsDef)
                    r.status = ST_FULL;
                else if (bad)
                    r.status = ST_BAD;
                else
                begin
                    term_tab[term_cnt] = '{it.term_target, it.term_degree, it.term_vars,
                                           it.term_coeff};
                    term_cnt++;
                    r.status = ST_OK;
                end
            end
            CMD_APPLY:
            begin
                xs[0] = 64'(it.coord_x);
                xs[1] = 64'(it.coord_y);
                xs[2] = 64'(it.coord_z);
                xs[3] = 64'(it.coord_u);
                xs[4] = 64'(it.coord_v);
                xs[5] = 64'(it.coord_w);
                for (int k = 0; k < NCoord; k++)
                    acc[k] = '0;
                for (int t = 0; t < term_cnt; t++)
                begin
                    v = 64'(term_tab[t].coeff);
                    for (int k = 0; k < term_tab[t].deg; k++)
                    begin
                        idx = term_tab[t].vars[3*k +: 3];
                        p = v * xs[idx];
                        // arithmetic shift gives floor rounding
                        v = clip32(p >>> 16, c);
                        sat |= c;
                    end
                    acc[term_tab[t].tgt] += v;
                end
                for (int k = 0; k < NCoord; k++)
                begin
                    acc[k] = clip32(acc[k], c);
                    sat |= c;
                end
                r.status = ST_DONE;
                r.out_x = acc[0][31:0];
                r.out_y = acc[1][31:0];
                r.out_z = acc[2][31:0];
                r.out_u = acc[3][31:0];
                r.out_v = acc[4][31:0];
                r.out_w = acc[5][31:0];
                r.saturated = sat;
            end
            default: r.status = ST_BAD;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 32'sh0;
                    3: return 32'sh10000;
                    default: return -32'sh10000;
                endcase
            end
            default: return $signed($urandom_range(0, 32'h7FFF)) + 32'shC000;
        endcase
    endfunction

    function automatic in_item_t noise_item();
        in_item_t it;
        it.cmd = 2'($urandom_range(0, 3));
        it.coord_x = $urandom;
        it.coord_y = $urandom;
        it.coord_z = $urandom;
        it.coord_u = $urandom;
        it.coord_v = $urandom;
        it.coord_w = $urandom;
        it.term_target = 3'($urandom);
        it.term_degree = 4'($urandom);
        it.term_vars = 24'($urandom);
        it.term_coeff = $urandom;
        return it;
    endfunction

    task automatic add_pending(input in_item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic push_cmd(input logic [1:0] c);
        in_item_t it;
        it = noise_item();
        it.cmd = c;
        add_pending(it);
    endtask

    task automatic push_load(input logic [2:0] tgt, input logic [3:0] deg,
                             input logic [23:0] vars, input logic signed [31:0] coeff);
        in_item_t it;
        it = noise_item();
        it.cmd = CMD_LOAD;
        it.term_target = tgt;
        it.term_degree = deg;
        it.term_vars = vars;
        it.term_coeff = coeff;
        add_pending(it);
    endtask

    task automatic push_apply(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z, input logic signed [31:0] u,
                              input logic signed [31:0] v, input logic signed [31:0] w);
        in_item_t it;
        it = noise_item();
        it.cmd = CMD_APPLY;
        {it.coord_x, it.coord_y, it.coord_z, it.coord_u, it.coord_v, it.coord_w} =
            {x, y, z, u, v, w};
        add_pending(it);
    endtask

    task automatic push_good_load();
        logic [23:0] vars;
        logic [3:0]  deg;
        vars = 24'($urandom);
        deg = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(5, MaxOrderDef))
                                          : 4'($urandom_range(1, 4));
        for (int k = 0; k < MaxOrderDef; k++)
            vars[3*k +: 3] = (k < deg) ? 3'($urandom_range(0, NCoord - 1)) : vars[3*k +: 3];
        push_load(3'($urandom_range(0, NCoord - 1)), deg, vars, pick_value());
    endtask

    task automatic push_rand_apply();
        push_apply(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
                   pick_value());
    endtask

    // driver: bursts with random gaps, sometimes holding until all results are back
    int burst_left = 3;
    int gap_left = 0;
    bit hold_drain = 1'b1;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results = {expected_results, map_step(in_ch.data)};
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (hold_drain && expected_results.size() != 0)
                    in_ch.valid <= 1'b0;
                else if (pending_items.size() != 0)
                begin
                    hold_drain = 1'b0;
                    in_ch.data <= pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        hold_drain = ($urandom_range(0, 15) == 0);
                    end
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor with its own stall pattern
    int stall_mode = 0;
    int mode_left = 0;
    int tick = 0;

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        out_item_t a;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                a = out_ch.data;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected transaction on output, status %0d", a.status);
                    failed = 1'b1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("status", 32'(e.status), 32'(a.status));
                    check_field("out_x", e.out_x, a.out_x);
                    check_field("out_y", e.out_y, a.out_y);
                    check_field("out_z", e.out_z, a.out_z);
                    check_field("out_u", e.out_u, a.out_u);
                    check_field("out_v", e.out_v, a.out_v);
                    check_field("out_w", e.out_w, a.out_w);
                    check_field("saturated", 32'(e.saturated), 32'(a.saturated));
                end
            end
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            tick++;
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= tick[0];
                default: out_ch.ready <= (tick % 7 == 0);
            endcase
        end
    end

    // watchdog on cycles with no transaction
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int nload;
        rst_n = 1'b0;

        // directed part
        push_rand_apply();                                        // empty table
        push_load(3'd0, 4'd1, 24'h0, 32'sh10000);
        push_load(3'd5, 4'(MaxOrderDef), 24'h000000, 32'sh7FFFFFFF);
        push_load(3'd1, 4'd2, {18'h3FFFF, 3'd5, 3'd4}, 32'sh80000000);  // unused index bits ignored
        push_load(3'd6, 4'd1, 24'h0, 32'sh10000);                  // bad target
        push_load(3'd7, 4'd1, 24'h0, 32'sh10000);
        push_load(3'd2, 4'd0, 24'h0, 32'sh10000);                  // degree zero
        push_load(3'd2, 4'd9, 24'h0, 32'sh10000);                  // degree too high
        push_load(3'd2, 4'd15, 24'h0, 32'sh10000);
        push_load(3'd3, 4'd3, {15'h0, 3'd6, 3'd1, 3'd2}, 32'sh10000);  // bad factor index
        push_load(3'd3, 4'd1, {21'h0, 3'd7}, 32'sh10000);
        push_load(3'd4, 4'd3, {15'h0, 3'd3, 3'd2, 3'd1}, -32'sh8000);
        push_cmd(2'd3);                                           // unused command
        push_apply(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0,
                   32'sh10000);
        push_apply(-32'sh10000, 32'sh8000, 32'sh18000, -32'sh1, 32'sh1, 32'sh20000);
        push_apply(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
        push_cmd(CMD_CLEAR);
        push_rand_apply();

        // fill the table to its limit, then overflow it
        for (int i = 0; i < MaxTermsDef; i++)
            push_good_load();
        push_load(3'd0, 4'd1, 24'h0, 32'sh10000);
        push_load(3'd7, 4'd0, 24'hFFFFFF, 32'sh10000);             // full wins over bad
        push_rand_apply();
        push_cmd(CMD_CLEAR);

        // random sequences: clear, loads, applies, some noise
        n = 0;
        while (n < RandItems)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_pending(noise_item());
                n++;
            end
            else
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    push_cmd(CMD_CLEAR);
                    n++;
                end
                nload = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                for (int i = 0; i < nload; i++)
                begin
                    if ($urandom_range(0, 11) == 0)
                        push_load(3'($urandom), 4'($urandom), 24'($urandom), $urandom);
                    else
                        push_good_load();
                    n++;
                end
                for (int i = $urandom_range(1, 4); i > 0; i--)
                begin
                    push_rand_apply();
                    n++;
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
